@@ src/pedestal_common_noise_subtract_top_macros.svh @@
// assertion macros for the pedestal and common noise subtraction block
`ifndef PEDESTAL_COMMON_NOISE_SUBTRACT_TOP_MACROS_SVH
`define PEDESTAL_COMMON_NOISE_SUBTRACT_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PCNS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define PCNS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/pcns_pkg.sv @@
// shared types and constants of the pedestal and common noise subtraction block
`default_nettype none

package pcns_pkg;

    localparam int VAL_W     = 16;
    localparam int RAW_W     = 12;
    localparam int FRAC_W    = 4;
    localparam int SUM_W     = 22;
    localparam int DIVISOR_W = 7;
    localparam int MOD_W     = 5;
    localparam int CHAN_W    = 6;
    localparam int MODE_W    = 2;

    localparam logic [MODE_W-1:0] MODE_RAW = 2'd3;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic                 start;
        logic [SUM_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

@@ src/pcns_div.sv @@
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module pcns_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  pcns_pkg::t_div_req     i_req,
    output pcns_pkg::t_div_rsp     o_rsp
);

    localparam int SW    = pcns_pkg::SUM_W;
    localparam int DVW   = pcns_pkg::DIVISOR_W;
    localparam int STEPW = $clog2(SW);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [STEPW-1:0] r_step, n_step;
    logic [SW-1:0]    r_quo, n_quo;
    logic [DVW-1:0]   r_rem, n_rem;
    logic [DVW-1:0]   r_div, n_div;
    logic [DVW:0]     shifted;
    logic [DVW:0]     diff;
    logic             ge;

    always_comb begin
        shifted = {r_rem, r_quo[SW-1]};
        diff    = shifted - {1'b0, r_div};
        ge      = (shifted >= {1'b0, r_div});
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_step  = r_step;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_div   = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            n_quo  = {r_quo[SW-2:0], ge};
            n_rem  = ge ? diff[DVW-1:0] : shifted[DVW-1:0];
            n_step = r_step + STEPW'(1);
            if (r_step == STEPW'(SW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

@@ src/pedestal_common_noise_subtract_top.sv @@
// top level: pedestal table, event buffer, common noise average and drain
//
// channel  | direction | handshake               | payload
// in       | in        | i_in_valid / o_in_ready | cmd, module_req, channel, value, hit,
//          |           |                         | event_mode, last
// out      | out       | o_out_valid/i_out_ready | out_channel, energy, out_hit, out_last
//
// a pedestal load leaves the input ready; a channel sample holds it through the pedestal memory read, then update
// a last sample adds a divide state, then waits for the divider when noise samples exist,
// then each buffered result passes a buffer memory read and an output register load
// reset clears control state only; the pedestal table is not cleared
// a stalled output holds the drain; loads and samples are taken while the final result waits
`default_nettype none

module pedestal_common_noise_subtract_top #(
    parameter int MODULES  = 25,
    parameter int CHANNELS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_cmd,
    input  wire logic [pcns_pkg::MOD_W-1:0]    i_module_req,
    input  wire logic [pcns_pkg::CHAN_W-1:0]   i_channel,
    input  wire logic [pcns_pkg::VAL_W-1:0]    i_value,
    input  wire logic                          i_hit,
    input  wire logic [pcns_pkg::MODE_W-1:0]   i_event_mode,
    input  wire logic                          i_last,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [pcns_pkg::CHAN_W-1:0]        o_out_channel,
    output logic [pcns_pkg::VAL_W-1:0]         o_energy,
    output logic                               o_out_hit,
    output logic                               o_out_last
);

    localparam int DEPTH = MODULES * CHANNELS;
    localparam int PA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW    = $clog2(CHANNELS);
    localparam int CW    = $clog2(CHANNELS + 1);
    localparam int VW    = pcns_pkg::VAL_W;
    localparam int SW    = pcns_pkg::SUM_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PED  = 6'b000010,
        S_DIV  = 6'b000100,
        S_WAIT = 6'b001000,
        S_RD   = 6'b010000,
        S_SHOW = 6'b100000
    } t_state;

    typedef struct packed {
        logic [pcns_pkg::CHAN_W-1:0] chan;
        logic                        hit;
        logic [VW-1:0]               v;
    } t_buf_word;

    t_state                      r_state, n_state;
    logic [CW-1:0]               r_sample_count, n_sample_count;
    logic [CW-1:0]               r_noise_count, n_noise_count;
    logic [SW-1:0]               r_noise_sum, n_noise_sum;
    logic [pcns_pkg::MOD_W-1:0]  r_ev_module, n_ev_module;
    logic [pcns_pkg::MODE_W-1:0] r_ev_mode, n_ev_mode;
    logic [VW-1:0]               r_raw, n_raw;
    logic                        r_hit, n_hit;
    logic [pcns_pkg::CHAN_W-1:0] r_chan, n_chan;
    logic                        r_last, n_last;
    logic                        r_ped_ok, n_ped_ok;
    logic [VW-1:0]               r_avg, n_avg;
    logic [CW-1:0]               r_k, n_k;
    logic                        r_out_valid, n_out_valid;
    logic [pcns_pkg::CHAN_W-1:0] r_out_channel, n_out_channel;
    logic [VW-1:0]               r_energy, n_energy;
    logic                        r_out_hit, n_out_hit;
    logic                        r_out_last, n_out_last;

    logic [VW-1:0]               r_ped_mem [DEPTH];
    logic [VW-1:0]               r_ped_q;
    t_buf_word                   r_buf_mem [CHANNELS];
    t_buf_word                   r_buf_q;

    logic                        in_acc;
    logic [pcns_pkg::MOD_W-1:0]  eff_module;
    logic                        addr_ok;
    logic [PA_W-1:0]             ped_addr;
    logic                        ped_we;
    logic                        buf_we;
    t_buf_word                   buf_wdata;
    logic [VW-1:0]               ped_use;
    logic [VW-1:0]               v_corr;
    logic                        out_free;
    pcns_pkg::t_div_req          div_req;
    pcns_pkg::t_div_rsp          div_rsp;

    pcns_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign in_acc     = i_in_valid && o_in_ready;
    assign eff_module = (i_cmd == pcns_pkg::CMD_LOAD || r_sample_count == '0)
                        ? i_module_req : r_ev_module;
    assign addr_ok    = (eff_module != '0) && (32'(eff_module) <= MODULES)
                        && (32'(i_channel) < CHANNELS);
    assign ped_addr   = PA_W'((32'(eff_module) - 32'd1) * CHANNELS + 32'(i_channel));
    assign ped_we     = in_acc && (i_cmd == pcns_pkg::CMD_LOAD) && addr_ok;
    assign ped_use    = r_ped_ok ? r_ped_q : '0;
    assign v_corr     = (r_ev_mode == pcns_pkg::MODE_RAW) ? r_raw
                        : ((r_raw > ped_use) ? (r_raw - ped_use) : '0);
    assign buf_we     = (r_state == S_PED) && (r_sample_count < CW'(CHANNELS));
    assign buf_wdata  = '{chan: r_chan, hit: r_hit, v: v_corr};
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state        = r_state;
        n_sample_count = r_sample_count;
        n_noise_count  = r_noise_count;
        n_noise_sum    = r_noise_sum;
        n_ev_module    = r_ev_module;
        n_ev_mode      = r_ev_mode;
        n_raw          = r_raw;
        n_hit          = r_hit;
        n_chan         = r_chan;
        n_last         = r_last;
        n_ped_ok       = r_ped_ok;
        n_avg          = r_avg;
        n_k            = r_k;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out_channel  = r_out_channel;
        n_energy       = r_energy;
        n_out_hit      = r_out_hit;
        n_out_last     = r_out_last;
        div_req.start    = 1'b0;
        div_req.dividend = r_noise_sum;
        div_req.divisor  = pcns_pkg::DIVISOR_W'(r_noise_count);

        case (r_state)
            S_IDLE: begin
                if (in_acc && i_cmd == pcns_pkg::CMD_SAMPLE) begin
                    if (r_sample_count == '0) begin
                        n_ev_module = i_module_req;
                        n_ev_mode   = i_event_mode;
                    end
                    n_raw    = {i_value[pcns_pkg::RAW_W-1:0], pcns_pkg::FRAC_W'(0)};
                    n_hit    = i_hit;
                    n_chan   = i_channel;
                    n_last   = i_last;
                    n_ped_ok = addr_ok;
                    n_state  = S_PED;
                end
            end
            S_PED: begin
                if (buf_we) begin
                    n_sample_count = r_sample_count + CW'(1);
                    if (r_ev_mode != pcns_pkg::MODE_RAW && !r_hit) begin
                        n_noise_sum   = r_noise_sum + SW'(v_corr);
                        n_noise_count = r_noise_count + CW'(1);
                    end
                end
                n_state = r_last ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                n_k = '0;
                if (r_ev_mode != pcns_pkg::MODE_RAW && r_noise_count != '0) begin
                    div_req.start = 1'b1;
                    n_state       = S_WAIT;
                end else begin
                    n_avg   = '0;
                    n_state = S_RD;
                end
            end
            S_WAIT: begin
                if (div_rsp.done) begin
                    n_avg   = div_rsp.quotient[VW-1:0];
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_SHOW;
            end
            S_SHOW: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_channel = r_buf_q.chan;
                    n_out_hit     = r_buf_q.hit;
                    n_energy      = (r_buf_q.v > r_avg) ? (r_buf_q.v - r_avg) : '0;
                    n_out_last    = ((r_k + CW'(1)) == r_sample_count);
                    n_k           = r_k + CW'(1);
                    if ((r_k + CW'(1)) == r_sample_count) begin
                        n_sample_count = '0;
                        n_noise_count  = '0;
                        n_noise_sum    = '0;
                        n_state        = S_IDLE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_sample_count <= '0;
            r_noise_count  <= '0;
            r_noise_sum    <= '0;
            r_ev_module    <= '0;
            r_ev_mode      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_sample_count <= n_sample_count;
            r_noise_count  <= n_noise_count;
            r_noise_sum    <= n_noise_sum;
            r_ev_module    <= n_ev_module;
            r_ev_mode      <= n_ev_mode;
            r_out_valid    <= n_out_valid;
        end
        r_raw         <= n_raw;
        r_hit         <= n_hit;
        r_chan        <= n_chan;
        r_last        <= n_last;
        r_ped_ok      <= n_ped_ok;
        r_avg         <= n_avg;
        r_k           <= n_k;
        r_out_channel <= n_out_channel;
        r_energy      <= n_energy;
        r_out_hit     <= n_out_hit;
        r_out_last    <= n_out_last;
    end

    // pedestal table, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (ped_we) begin
            r_ped_mem[ped_addr] <= i_value;
        end
        r_ped_q <= r_ped_mem[ped_addr];
    end

    // event buffer
    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            r_buf_mem[r_sample_count[BW-1:0]] <= buf_wdata;
        end
        if (r_state == S_RD) begin
            r_buf_q <= r_buf_mem[r_k[BW-1:0]];
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_channel;
    assign o_energy      = r_energy;
    assign o_out_hit     = r_out_hit;
    assign o_out_last    = r_out_last;

endmodule

`default_nettype wire

@@ src/pcns_checker.sv @@
// port-level checks of the pedestal and common noise subtraction block, with bind
`default_nettype none

`include "pedestal_common_noise_subtract_top_macros.svh"

module pcns_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_ready,
    input wire logic                        i_cmd,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [pcns_pkg::CHAN_W-1:0] o_out_channel,
    input wire logic [pcns_pkg::VAL_W-1:0]  o_energy,
    input wire logic                        o_out_hit,
    input wire logic                        o_out_last
);

    logic in_load;
    logic in_sample;

    assign in_load   = i_in_valid && o_in_ready && (i_cmd == pcns_pkg::CMD_LOAD);
    assign in_sample = i_in_valid && o_in_ready && (i_cmd == pcns_pkg::CMD_SAMPLE);

    // a stalled result holds
    `PCNS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_energy) && $stable(o_out_channel)
            && $stable(o_out_hit) && $stable(o_out_last),
        "stalled result changed")

    // a pedestal load never stalls the input
    `PCNS_ASSERT_NEXT(a_load_ready, i_clk, i_rst_n, in_load, o_in_ready,
        "input not ready after a pedestal load")

    // a sample occupies the block while it is updated
    `PCNS_ASSERT_NEXT(a_sample_busy, i_clk, i_rst_n, in_sample, !o_in_ready,
        "input ready right after a sample")

    // while the drain is mid-event no new request is taken
    `PCNS_ASSERT_NOW(a_drain_busy, i_clk, i_rst_n, o_out_valid && !o_out_last, !o_in_ready,
        "input ready during an event drain")

endmodule

bind pedestal_common_noise_subtract_top pcns_checker u_pcns_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_cmd         (i_cmd),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_channel (o_out_channel),
    .o_energy      (o_energy),
    .o_out_hit     (o_out_hit),
    .o_out_last    (o_out_last)
);

`default_nettype wire
